FILE: design/rfcd_pkg.sv
`default_nettype none

package rfcd_pkg;

    localparam int unsigned POS_W     = 9;
    localparam int unsigned HDR_BYTES = 12;
    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

    // header byte positions
    localparam logic [3:0] HB_TYPE   = 4'd0;
    localparam logic [3:0] HB_SOURCE = 4'd1;
    localparam logic [3:0] HB_DEST   = 4'd2;
    localparam logic [3:0] HB_TXID_H = 4'd3;
    localparam logic [3:0] HB_TXID_L = 4'd4;
    localparam logic [3:0] HB_STAMP0 = 4'd5;
    localparam logic [3:0] HB_STAMP1 = 4'd6;
    localparam logic [3:0] HB_STAMP2 = 4'd7;
    localparam logic [3:0] HB_STAMP3 = 4'd8;
    localparam logic [3:0] HB_STAMP4 = 4'd9;
    localparam logic [3:0] HB_STAMP5 = 4'd10;
    localparam logic [3:0] HB_LENGTH = 4'd11;

    // summary status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [1:0]  status;
        logic [7:0]  frame_type;
        logic [7:0]  source_id;
        logic [7:0]  dest_id;
        logic [15:0] transmission_id;
        logic [47:0] date_time;
        logic [7:0]  data_length;
    } res_t;

endpackage

`default_nettype wire

FILE: design/rfcd_if.sv
`default_nettype none

interface rfcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rfcd_out_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [15:0] transmission_id;
    logic [47:0] date_time;
    logic [7:0]  data_length;

    modport source (
        output valid, output is_summary, output data_byte, output data_index,
        output status, output frame_type, output source_id, output dest_id,
        output transmission_id, output date_time, output data_length,
        input ready
    );
    modport sink (
        input valid, input is_summary, input data_byte, input data_index,
        input status, input frame_type, input source_id, input dest_id,
        input transmission_id, input date_time, input data_length,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/rfcd_core.sv
`default_nettype none

module rfcd_core
    import rfcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_end,
    output logic            push,
    output res_t            res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       source_reg, source_next;
    logic [7:0]       dest_reg, dest_next;
    logic [15:0]      txid_reg, txid_next;
    logic [47:0]      stamp_reg, stamp_next;
    logic [7:0]       length_reg, length_next;
    logic [POS_W-1:0] data_off;

    assign data_off = pos_reg - HDR_LAST;

    always_comb
    begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        type_next   = type_reg;
        source_next = source_reg;
        dest_next   = dest_reg;
        txid_next   = txid_reg;
        stamp_next  = stamp_reg;
        length_next = length_reg;
        push        = 1'b0;
        res         = '0;

        if (accept && frame_end)
        begin
            push                = 1'b1;
            res.is_summary      = 1'b1;
            res.frame_type      = type_reg;
            res.source_id       = source_reg;
            res.dest_id         = dest_reg;
            res.transmission_id = txid_reg;
            res.date_time       = stamp_reg;
            res.data_length     = length_reg;
            // fewer than 13 bytes including the checksum byte
            if (pos_reg < HDR_LAST)
                res.status = STATUS_SHORT;
            else if (xor_reg != rx_byte)
                res.status = STATUS_BAD;
            else
                res.status = STATUS_OK;
            pos_next    = '0;
            xor_next    = '0;
            type_next   = '0;
            source_next = '0;
            dest_next   = '0;
            txid_next   = '0;
            stamp_next  = '0;
            length_next = '0;
        end
        else if (accept)
        begin
            xor_next = xor_reg ^ rx_byte;
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + POS_W'(1'b1);

            if (pos_reg < HDR_LAST)
            begin
                unique case (pos_reg[3:0])
                    HB_TYPE:   type_next          = rx_byte;
                    HB_SOURCE: source_next        = rx_byte;
                    HB_DEST:   dest_next          = rx_byte;
                    HB_TXID_H: txid_next[15:8]    = rx_byte;
                    HB_TXID_L: txid_next[7:0]     = rx_byte;
                    HB_STAMP0: stamp_next[47:40]  = rx_byte;
                    HB_STAMP1: stamp_next[39:32]  = rx_byte;
                    HB_STAMP2: stamp_next[31:24]  = rx_byte;
                    HB_STAMP3: stamp_next[23:16]  = rx_byte;
                    HB_STAMP4: stamp_next[15:8]   = rx_byte;
                    HB_STAMP5: stamp_next[7:0]    = rx_byte;
                    HB_LENGTH: length_next        = rx_byte;
                    default:   length_next        = length_reg;
                endcase
            end
            else if (data_off < {1'b0, length_reg})
            begin
                push           = 1'b1;
                res.data_byte  = rx_byte;
                res.data_index = data_off[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            xor_reg    <= '0;
            type_reg   <= '0;
            source_reg <= '0;
            dest_reg   <= '0;
            txid_reg   <= '0;
            stamp_reg  <= '0;
            length_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            source_reg <= source_next;
            dest_reg   <= dest_next;
            txid_reg   <= txid_next;
            stamp_reg  <= stamp_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/rfcd_skid.sv
`default_nettype none

module rfcd_skid
    import rfcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire res_t   res,
    output logic        in_ready,
    rfcd_out_if.source  out
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop      = main_valid_reg && out.ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out.valid           = main_valid_reg;
    assign out.is_summary      = main_reg.is_summary;
    assign out.data_byte       = main_reg.data_byte;
    assign out.data_index      = main_reg.data_index;
    assign out.status          = main_reg.status;
    assign out.frame_type      = main_reg.frame_type;
    assign out.source_id       = main_reg.source_id;
    assign out.dest_id         = main_reg.dest_id;
    assign out.transmission_id = main_reg.transmission_id;
    assign out.date_time       = main_reg.date_time;
    assign out.data_length     = main_reg.data_length;

endmodule

`default_nettype wire

FILE: design/radio_frame_checker_deframer.sv
`default_nettype none

// channel  dir  payload                                            handshake
// rx       in   rx_byte[7:0], frame_end                            valid/ready
// res      out  is_summary, data_byte, data_index, status,         valid/ready
//               frame_type, source_id, dest_id, transmission_id,
//               date_time[47:0], data_length
//
// one word per cycle while rx.ready is high; a taken byte's result goes into the result register
// when that register is free or being read, else into the skid slot; each byte makes a
// single state update in the core
// rst_n clears the byte position, running xor, captured header and the valid flags of both
// output slots at once
// a stalled res fills the result register, then the skid slot; rx.ready
// drops only while the skid slot is full

module radio_frame_checker_deframer
    import rfcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rfcd_in_if.sink    rx,
    rfcd_out_if.source res
);

    logic accept;
    logic push;
    logic in_ready;
    res_t core_res;

    // byte taken this cycle
    assign accept   = rx.valid && rx.ready;
    assign rx.ready = in_ready;

    // position counter, xor, header capture and result build
    rfcd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .frame_end (rx.frame_end),
        .push      (push),
        .res       (core_res)
    );

    // result register with a skid slot behind it
    rfcd_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (core_res),
        .in_ready (in_ready),
        .out      (res)
    );

    // a stalled input means both result slots are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> res.valid)
        else $error("rx stalled with no pending result");

    // res is valid in the cycle after the final byte of a frame is taken
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready && rx.frame_end) |=> res.valid)
        else $error("frame end produced no summary");

    // data words carry no header or status
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.is_summary) |->
            (res.status == STATUS_OK && res.data_length == 8'd0
             && res.transmission_id == 16'd0))
        else $error("data word carries summary fields");

endmodule

`default_nettype wire

FILE: tb/radio_frame_checker_deframer_test.sv
`timescale 1ns / 1ps

module radio_frame_checker_deframer_test;
    import rfcd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // clock and reset
    logic clk;
    logic rst_n = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    rfcd_in_if  rx_if ();
    rfcd_out_if res_if ();

    radio_frame_checker_deframer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // deframer state as the testbench sees it
    logic [8:0]  frame_pos;
    logic [7:0]  frame_xor;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_source;
    logic [7:0]  hdr_dest;
    logic [15:0] hdr_txid;
    logic [47:0] hdr_stamp;
    logic [7:0]  hdr_length;

    // words the block still owes us, oldest first
    res_t pending_words[$];

    // run bookkeeping
    int  errors          = 0;
    int  bytes_sent      = 0;
    int  frames_sent     = 0;
    int  data_words      = 0;
    int  ok_summaries    = 0;
    int  bad_summaries   = 0;
    int  short_summaries = 0;
    int  rx_stall_cycles = 0;
    bit  gaps_on         = 1'b1;
    int  hold_req        = 0;

    // idle length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic string show(res_t r);
        return $sformatf({"sum=%0d byte=%h idx=%0d st=%0d type=%h src=%h dst=%h ",
                          "txid=%h dt=%h len=%h"},
                         r.is_summary, r.data_byte, r.data_index, r.status,
                         r.frame_type, r.source_id, r.dest_id, r.transmission_id,
                         r.date_time, r.data_length);
    endfunction

    task automatic clear_frame();
        frame_pos  = '0;
        frame_xor  = '0;
        hdr_type   = '0;
        hdr_source = '0;
        hdr_dest   = '0;
        hdr_txid   = '0;
        hdr_stamp  = '0;
        hdr_length = '0;
    endtask

    // advance the deframer by one accepted byte and queue any word it yields
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        res_t       r;
        logic [8:0] pos;
        int         sh;
        r   = '0;
        pos = frame_pos;
        if (last)
        begin
            r.is_summary = 1'b1;
            // fewer than 13 bytes with the final one counted
            if (pos < HDR_LAST)
                r.status = STATUS_SHORT;
            else if (frame_xor != b)
                r.status = STATUS_BAD;
            else
                r.status = STATUS_OK;
            r.frame_type      = hdr_type;
            r.source_id       = hdr_source;
            r.dest_id         = hdr_dest;
            r.transmission_id = hdr_txid;
            r.date_time       = hdr_stamp;
            r.data_length     = hdr_length;
            pending_words = {pending_words, r};
            clear_frame();
        end
        else
        begin
            frame_xor = frame_xor ^ b;
            if (frame_pos != POS_MAX)
                frame_pos = frame_pos + 9'd1;
            if (pos < HDR_LAST)
            begin
                case (pos[3:0]) inside
                    HB_TYPE:   hdr_type = b;
                    HB_SOURCE: hdr_source = b;
                    HB_DEST:   hdr_dest = b;
                    HB_TXID_H: hdr_txid[15:8] = b;
                    HB_TXID_L: hdr_txid[7:0] = b;
                    HB_STAMP0, HB_STAMP1, HB_STAMP2, HB_STAMP3, HB_STAMP4, HB_STAMP5:
                    begin
                        sh = 8 * (int'(HB_STAMP5) - int'(pos));
                        hdr_stamp[sh +: 8] = b;
                    end
                    HB_LENGTH: hdr_length = b;
                    default: ;
                endcase
            end
            else if (pos - HDR_LAST < {1'b0, hdr_length})
            begin
                // inside the declared data window
                r.data_byte  = b;
                r.data_index = 8'(pos - HDR_LAST);
                pending_words = {pending_words, r};
            end
        end
    endtask

    // offer one word on rx, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = gaps_on ? pick_gap() : 0;
        if (g > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.rx_byte   <= b;
        rx_if.frame_end <= last;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            rx_stall_cycles++;
            @(posedge clk);
        end
        deframe_byte(b, last);
        bytes_sent++;
    endtask

    // send a frame body and close it with its xor, optionally with one bit flipped
    task automatic send_body(input byte_q_t body, input bit corrupt);
        logic [7:0] sum;
        sum = '0;
        foreach (body[i])
        begin
            sum = sum ^ body[i];
            send_byte(body[i], 1'b0);
        end
        if (corrupt)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(sum, 1'b1);
        frames_sent++;
    endtask

    // random header declaring some data length, then the given number of data bytes
    function automatic byte_q_t build_frame(input logic [7:0] declared, input int sent);
        byte_q_t q;
        for (int i = 0; i < HDR_BYTES - 1; i++)
            q = {q, 8'($urandom)};
        q = {q, declared};
        for (int i = 0; i < sent; i++)
            q = {q, 8'($urandom)};
        return q;
    endfunction

    function automatic byte_q_t random_bytes(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q = {q, 8'($urandom)};
        return q;
    endfunction

    // frames cut off before or inside the header
    task automatic test_short_frames();
        send_byte(8'hff, 1'b1);
        frames_sent++;
        send_body(random_bytes(11), 1'b0);
        send_body(random_bytes(6), 1'b1);
    endtask

    // all-zero and all-ones headers; the all-ones one stops well short of its 255 bytes
    task automatic test_header_extremes();
        byte_q_t q;
        for (int i = 0; i < HDR_BYTES; i++)
            q = {q, 8'h00};
        send_body(q, 1'b0);
        q.delete();
        for (int i = 0; i < HDR_BYTES; i++)
            q = {q, 8'hff};
        q = {q, 8'h00};
        q = {q, 8'hff};
        send_body(q, 1'b0);
    endtask

    // minimum legal frame and a short data frame, each with a bad checksum, then the short one with a good checksum
    task automatic test_checksum();
        send_body(build_frame(8'd0, 0), 1'b1);
        send_body(build_frame(8'd3, 3), 1'b1);
        send_body(build_frame(8'd3, 3), 1'b0);
    endtask

    // trailing bytes past the declared data still enter the xor
    task automatic test_long_frame();
        send_body(build_frame(8'd2, 8), 1'b0);
    endtask

    // full data window, then enough trailer to pin the byte position at its limit
    task automatic test_saturation();
        send_body(build_frame(8'd255, 505), 1'b0);
    endtask

    // receiver holds off long enough that both output slots fill and rx stalls
    task automatic test_receiver_holdoff();
        gaps_on  = 1'b0;
        hold_req = 200;
        send_body(build_frame(8'd24, 24), 1'b0);
        send_body(build_frame(8'd10, 10), 1'b0);
        gaps_on  = 1'b1;
    endtask

    // mostly well-formed frames with random content, plus broken ones
    task automatic test_random_frames();
        int r;
        int declared;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 80)
        begin
            r = $urandom_range(0, 99);
            declared = $urandom_range(0, 12);
            // idle gaps switched on or off now and then
            if ($urandom_range(0, 9) == 0)
                gaps_on = ~gaps_on;
            if (r < 60)
                send_body(build_frame(8'(declared), declared), 1'b0);
            else if (r < 70)
                send_body(build_frame(8'(declared), declared), 1'b1);
            else if (r < 80)
                send_body(random_bytes($urandom_range(0, 11)), $urandom_range(0, 1));
            else if (r < 90)
                send_body(build_frame(8'(declared), declared + $urandom_range(1, 6)),
                          $urandom_range(0, 1));
            else
            begin
                declared = $urandom_range(1, 20);
                send_body(build_frame(8'(declared), $urandom_range(0, declared - 1)),
                          $urandom_range(0, 1));
            end
        end
        gaps_on = 1'b1;
    endtask

    // result side: random readiness, plus a long hold-off on request
    initial
    begin
        int n;
        int g;
        res_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                n        = hold_req;
                hold_req = 0;
                res_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                g = gaps_on ? pick_gap() : 0;
                if (g > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // compare every taken result with the oldest pending word
    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.is_summary      = res_if.is_summary;
            got.data_byte       = res_if.data_byte;
            got.data_index      = res_if.data_index;
            got.status          = res_if.status;
            got.frame_type      = res_if.frame_type;
            got.source_id       = res_if.source_id;
            got.dest_id         = res_if.dest_id;
            got.transmission_id = res_if.transmission_id;
            got.date_time       = res_if.date_time;
            got.data_length     = res_if.data_length;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word at %0t: %s", $realtime, show(got));
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
            if (!got.is_summary)
                data_words++;
            else if (got.status == STATUS_OK)
                ok_summaries++;
            else if (got.status == STATUS_BAD)
                bad_summaries++;
            else if (got.status == STATUS_SHORT)
                short_summaries++;
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #15_000_000;
        $display("radio_frame_checker_deframer test failed");
        $finish;
    end

    initial
    begin
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = 8'h00;
        rx_if.frame_end = 1'b0;
        clear_frame();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_header_extremes();
        test_checksum();
        test_long_frame();
        test_saturation();
        test_receiver_holdoff();
        test_random_frames();

        rx_if.valid <= 1'b0;
        // drain, then give the result register and skid slot time to show strays
        while (pending_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d frames; rx held off for %0d cycles",
                 bytes_sent, frames_sent, rx_stall_cycles);
        $display("took %0d data words and %0d/%0d/%0d ok/bad-checksum/short summaries",
                 data_words, ok_summaries, bad_summaries, short_summaries);
        if (errors == 0)
            $display("radio_frame_checker_deframer test passed");
        else
            $display("radio_frame_checker_deframer test failed");
        $finish;
    end

endmodule
